// File: src/sitda_pkg.sv
package sitda_pkg;

    localparam int C_VALUE_W         = 32;
    localparam int C_CHAR_W          = 8;
    localparam int C_DIGITS          = 10;
    localparam int C_DIGIT_W         = 4;
    localparam int C_BCD_W           = C_DIGITS * C_DIGIT_W;
    localparam int C_POS_W           = $clog2(C_DIGITS);
    localparam int C_STEPS_PER_STAGE = 8;

    localparam logic [C_CHAR_W-1:0]  C_CHAR_ZERO  = 8'd48;
    localparam logic [C_CHAR_W-1:0]  C_CHAR_MINUS = 8'd45;
    localparam logic [C_CHAR_W-1:0]  C_CHAR_NINE  = 8'd57;
    localparam logic [C_DIGIT_W-1:0] C_DABBLE_MIN = 4'd5;
    localparam logic [C_DIGIT_W-1:0] C_DABBLE_ADD = 4'd3;

    // word in flight through the conversion pipe
    typedef struct packed {
        logic                 neg;
        logic [C_BCD_W-1:0]   bcd;
        logic [C_VALUE_W-1:0] bin;
    } t_dd;

endpackage

// File: src/sitda_dd_stage.sv
module sitda_dd_stage #(
    parameter int P_STEPS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  sitda_pkg::t_dd   i_data,
    output logic             o_ready,
    output logic             o_valid,
    output sitda_pkg::t_dd   o_data,
    input  logic             i_ready
);
    import sitda_pkg::*;

    logic r_valid;
    t_dd  r_data;
    t_dd  n_data;

    // P_STEPS shift-and-add-3 steps of double dabble
    always_comb begin
        logic [C_BCD_W+C_VALUE_W-1:0] acc;
        logic [C_DIGIT_W-1:0]         dig;
        acc = {i_data.bcd, i_data.bin};
        for (int s = 0; s < P_STEPS; s++) begin
            for (int d = 0; d < C_DIGITS; d++) begin
                dig = acc[C_VALUE_W + d*C_DIGIT_W +: C_DIGIT_W];
                if (dig >= C_DABBLE_MIN) begin
                    acc[C_VALUE_W + d*C_DIGIT_W +: C_DIGIT_W] = dig + C_DABBLE_ADD;
                end
            end
            acc = acc << 1;
        end
        n_data.neg = i_data.neg;
        n_data.bcd = acc[C_BCD_W+C_VALUE_W-1:C_VALUE_W];
        n_data.bin = acc[C_VALUE_W-1:0];
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// File: src/sitda_emit.sv
module sitda_emit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  sitda_pkg::t_dd                    i_data,
    output logic                              o_ready,
    output logic                              o_valid,
    output logic [sitda_pkg::C_CHAR_W-1:0]    o_ascii_char,
    output logic                              o_last_char
);
    import sitda_pkg::*;

    logic                 r_active;
    logic                 r_neg;
    logic [C_POS_W-1:0]   r_pos;
    logic [C_DIGIT_W-1:0] r_digits [C_DIGITS];
    logic                 r_valid;
    logic [C_CHAR_W-1:0]  r_char;
    logic                 r_last;

    logic [C_POS_W-1:0]   n_lead;
    logic [C_CHAR_W-1:0]  n_char;
    logic                 n_last;

    // most significant non-zero digit; zero prints as one '0'
    always_comb begin
        n_lead = '0;
        for (int i = 0; i < C_DIGITS; i++) begin
            if (i_data.bcd[i*C_DIGIT_W +: C_DIGIT_W] != '0) begin
                n_lead = C_POS_W'(i);
            end
        end
    end

    always_comb begin
        if (r_neg) begin
            n_char = C_CHAR_MINUS;
        end else begin
            n_char = C_CHAR_ZERO + C_CHAR_W'(r_digits[r_pos]);
        end
        n_last = !r_neg && (r_pos == '0);
    end

    assign o_ready      = !r_active || n_last;
    assign o_valid      = r_valid;
    assign o_ascii_char = r_char;
    assign o_last_char  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_neg    <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= r_active;
            if (r_active) begin
                if (r_neg) begin
                    r_neg <= 1'b0;
                end else if (n_last) begin
                    r_active <= 1'b0;
                end
            end
            if (o_ready && i_valid) begin
                r_active <= 1'b1;
                r_neg    <= i_data.neg;
            end
        end
        r_char <= n_char;
        r_last <= n_last;
        if (r_active && !r_neg && !n_last) begin
            r_pos <= r_pos - C_POS_W'(1);
        end
        if (o_ready && i_valid) begin
            r_pos <= n_lead;
            for (int i = 0; i < C_DIGITS; i++) begin
                r_digits[i] <= i_data.bcd[i*C_DIGIT_W +: C_DIGIT_W];
            end
        end
    end

endmodule

// File: src/signed_int_to_decimal_ascii_top.sv
// A taken word goes through the input register, the dd stages, the character unit.
// Throughput: one character per cycle; a number of n characters (1 to 11)
//   holds the character unit until its last one, the pipe ahead absorbs the gap.
// o_busy rises only when the double-dabble pipe is full behind the character unit.
// Reset (synchronous, active low) empties the pipe; here the receiver cannot stall.
module signed_int_to_decimal_ascii_top #(
    parameter int P_STEPS_PER_STAGE = sitda_pkg::C_STEPS_PER_STAGE
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic signed [sitda_pkg::C_VALUE_W-1:0] i_value,
    output logic                              o_valid,
    output logic [sitda_pkg::C_CHAR_W-1:0]    o_ascii_char,
    output logic                              o_last_char
);
    import sitda_pkg::*;

    // number of double-dabble stages; P_STEPS_PER_STAGE must divide the word width
    localparam int L_STAGES = C_VALUE_W / P_STEPS_PER_STAGE;

    // input stage: sign and magnitude
    logic r_s0_valid;
    t_dd  r_s0;
    logic s0_ready;
    logic accept;

    // pipe links, index 0 is the input stage output
    logic stg_valid [L_STAGES+1];
    t_dd  stg_data  [L_STAGES+1];
    logic stg_ready [L_STAGES+1];

    assign s0_ready = !r_s0_valid || stg_ready[0];
    assign o_busy   = !s0_ready;
    assign accept   = i_start && s0_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (s0_ready) begin
            r_s0_valid <= i_start;
        end
        if (accept) begin
            // magnitude taken unsigned, so the most negative word stays exact
            r_s0.neg <= i_value[C_VALUE_W-1];
            r_s0.bin <= i_value[C_VALUE_W-1] ? (C_VALUE_W'(0) - C_VALUE_W'(i_value))
                                             : C_VALUE_W'(i_value);
            r_s0.bcd <= '0;
        end
    end

    assign stg_valid[0] = r_s0_valid;
    assign stg_data[0]  = r_s0;

    for (genvar g = 0; g < L_STAGES; g++) begin : g_dd
        sitda_dd_stage #(
            .P_STEPS (P_STEPS_PER_STAGE)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[g]),
            .i_data  (stg_data[g]),
            .o_ready (stg_ready[g]),
            .o_valid (stg_valid[g+1]),
            .o_data  (stg_data[g+1]),
            .i_ready (stg_ready[g+1])
        );
    end

    // character unit: '-' then digits, most significant first
    sitda_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (stg_valid[L_STAGES]),
        .i_data       (stg_data[L_STAGES]),
        .o_ready      (stg_ready[L_STAGES]),
        .o_valid      (o_valid),
        .o_ascii_char (o_ascii_char),
        .o_last_char  (o_last_char)
    );

`ifndef SYNTHESIS
    // a minus sign never ends a number
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_ascii_char == C_CHAR_MINUS) |-> !o_last_char)
        else $error("minus sign marked as last character");

    // only '-' or a decimal digit leaves the block
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_ascii_char == C_CHAR_MINUS) ||
                    ((o_ascii_char >= C_CHAR_ZERO) && (o_ascii_char <= C_CHAR_NINE)))
        else $error("illegal output character");

    // characters of one number leave without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_char |=> o_valid)
        else $error("gap inside a number");

    // no leading zero after a minus sign
    a_no_lead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(o_valid) && ($past(o_ascii_char) == C_CHAR_MINUS)
        |-> o_ascii_char != C_CHAR_ZERO)
        else $error("leading zero after minus sign");

    // reset leaves no stray word on the output
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word after reset");
`endif

endmodule

// File: tb/tb_signed_int_to_decimal_ascii_top.sv
`timescale 1ns / 100ps

module tb_signed_int_to_decimal_ascii_top;

    import sitda_pkg::*;

    // one expected output word: a character and its end-of-number mark
    typedef struct {
        logic [C_CHAR_W-1:0] ch;
        logic                last;
    } t_char_due;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_start = 1'b0;
    logic                        o_busy;
    logic signed [C_VALUE_W-1:0] i_value = '0;
    logic                        o_valid;
    logic [C_CHAR_W-1:0]         o_ascii_char;
    logic                        o_last_char;

    // numbers waiting to be offered, and characters still owed by the block
    logic signed [C_VALUE_W-1:0] numbers_to_send[$];
    t_char_due                   chars_due[$];
    int unsigned                 mismatches = 0;

    // driver pacing
    int unsigned gap_left      = 0;
    int unsigned no_gap_run    = 0;

    signed_int_to_decimal_ascii_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_ascii_char(o_ascii_char),
        .o_last_char (o_last_char)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // reset held low from the start, released once and never asserted again
    initial begin
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic flag_mismatch(input string what);
        $display("%0t: mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Spell a number out as the characters the block owes: an optional
    // minus, then the digits of the magnitude, most significant first.
    // The magnitude is taken as unsigned so the most negative value works.
    function automatic void spell_decimal(input logic signed [C_VALUE_W-1:0] num);
        logic                 neg;
        logic [C_VALUE_W-1:0] mag;
        logic [3:0]           digit[C_DIGITS];
        int                   n_digits;
        t_char_due            w;
        neg      = num[C_VALUE_W-1];
        mag      = neg ? (32'd0 - num) : num;
        n_digits = 0;
        if (mag == 0) begin
            w.ch   = C_CHAR_ZERO;
            w.last = 1'b1;
            chars_due.push_back(w);
            return;
        end
        if (neg) begin
            w.ch   = C_CHAR_MINUS;
            w.last = 1'b0;
            chars_due.push_back(w);
        end
        while (mag != 0) begin
            digit[n_digits] = 4'(mag % 10);
            mag             = mag / 10;
            n_digits++;
        end
        for (int k = n_digits - 1; k >= 0; k--) begin
            w.ch   = C_CHAR_ZERO + C_CHAR_W'(digit[k]);
            w.last = (k == 0);
            chars_due.push_back(w);
        end
    endfunction

    // Random number, half the time with a chosen digit count so every length
    // from 1 to 10 digits turns up often; the rest are raw bit patterns,
    // values around powers of ten and small values either side of zero.
    function automatic logic signed [C_VALUE_W-1:0] draw_number();
        longint      p10;
        int unsigned lo;
        int unsigned hi;
        longint      v;
        int          k;
        v = 0;
        case ($urandom_range(0, 5))
            0: v = longint'($signed($urandom));
            1, 2, 3: begin
                k   = int'($urandom_range(1, 10));
                p10 = 1;
                repeat (k - 1) p10 = p10 * 10;
                lo  = (k == 1) ? 32'd1 : 32'(p10);
                hi  = (p10 * 10 - 1 > 64'd2147483647) ? 32'd2147483647 : 32'(p10 * 10 - 1);
                v   = longint'($urandom_range(hi, lo));
                if ($urandom_range(0, 1)) v = -v;
            end
            4: begin
                p10 = 1;
                repeat ($urandom_range(0, 9)) p10 = p10 * 10;
                v   = p10 + longint'($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1)) v = -v;
            end
            default: v = longint'($urandom_range(0, 40)) - 20;
        endcase
        return v[C_VALUE_W-1:0];
    endfunction

    // stimulus: directed corners first, then random numbers
    initial begin
        numbers_to_send.push_back(32'sd0);
        numbers_to_send.push_back(32'sd1);
        numbers_to_send.push_back(-32'sd1);
        numbers_to_send.push_back(32'sd9);
        numbers_to_send.push_back(32'sd10);
        numbers_to_send.push_back(-32'sd9);
        numbers_to_send.push_back(-32'sd10);
        numbers_to_send.push_back(32'sd99);
        numbers_to_send.push_back(32'sd100);
        numbers_to_send.push_back(32'sd2147483647);
        numbers_to_send.push_back(32'h8000_0000);      // most negative: 11 chars
        numbers_to_send.push_back(-32'sd2147483647);
        numbers_to_send.push_back(32'sd999999999);
        numbers_to_send.push_back(32'sd1000000000);
        numbers_to_send.push_back(-32'sd999999999);
        numbers_to_send.push_back(-32'sd1000000000);
        numbers_to_send.push_back(32'sd1234567890);
        numbers_to_send.push_back(-32'sd123456789);
        numbers_to_send.push_back(32'sd0);
        numbers_to_send.push_back(32'sh5555_5555);
        numbers_to_send.push_back(32'shAAAA_AAAA);
        numbers_to_send.push_back(-32'sd7);
        repeat (258) numbers_to_send.push_back(draw_number());
    end

    // Driver: a word is taken at an edge where start is high and busy low.
    // Start and value get exactly one nonblocking write per edge, so a
    // back-to-back word keeps start high without a glitch.
    always @(posedge i_clk) begin
        logic                        nxt_start;
        logic signed [C_VALUE_W-1:0] nxt_value;
        nxt_start = i_start;
        nxt_value = i_value;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                spell_decimal(i_value);
                nxt_start = 1'b0;
                // occasional runs with no idling between words
                if (no_gap_run == 0 && $urandom_range(0, 7) == 0)
                    no_gap_run = $urandom_range(10, 30);
                if (no_gap_run > 0) begin
                    no_gap_run--;
                    gap_left = 0;
                end else begin
                    gap_left = $urandom_range(0, 3);
                end
            end
            if (!nxt_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (numbers_to_send.size() > 0) begin
                    nxt_value = numbers_to_send.pop_front();
                    nxt_start = 1'b1;
                end
            end
        end
        i_start <= nxt_start;
        i_value <= nxt_value;
    end

    // Monitor: each strobed character is taken at the edge ending its cycle.
    always @(posedge i_clk) begin
        t_char_due w;
        if (i_rst_n && o_valid) begin
            if (chars_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                        o_ascii_char, o_last_char));
            end else begin
                w = chars_due.pop_front();
                if (o_ascii_char !== w.ch)
                    flag_mismatch($sformatf("char 0x%02h, want 0x%02h",
                                            o_ascii_char, w.ch));
                if (o_last_char !== w.last)
                    flag_mismatch($sformatf("last mark %0b, want %0b on char 0x%02h",
                                            o_last_char, w.last, w.ch));
            end
        end
    end

    // end of run: everything offered and everything owed, then a short tail
    // so stray characters after the last number are still caught
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (numbers_to_send.size() != 0 || i_start || chars_due.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog: roughly 300 words need well below this
    initial begin
        #2ms;
        $display("timeout with %0d chars still due", chars_due.size());
        $display("status: fail");
        $finish;
    end

endmodule
